### rtl/core/sfs_pkg.sv
// shared types and constants of the sprite frame sequencer
`default_nettype none

package sfs_pkg;

    localparam int FRAME_W    = 6;
    localparam int FRAME_SPAN = 64;
    localparam int ELAPSED_W  = 16;
    localparam int DUR_W      = 16;
    localparam int CMD_W      = 2;
    localparam int MODE_W     = 2;
    localparam int REG_IDX_W  = 2;
    localparam int REG_DATA_W = 6;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FORWARD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BACKWARD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_FIRST_FRAME = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LAST_FRAME  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PLAY_MODE   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [ELAPSED_W-1:0] elapsed;
        logic [FRAME_W-1:0]   entry_index;
        logic [DUR_W-1:0]     entry_duration;
    } sfs_in_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_now;
        logic               frame_changed;
        logic               going_forward;
    } sfs_out_t;

endpackage

`default_nettype wire

### rtl/core/sfs_stream_if.sv
// valid/ready stream interface carrying one payload word
`default_nettype none

interface sfs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/sprite_frame_sequencer.sv
// sprite animation frame sequencer with per-frame duration table
//
// channels: req (sink) carries command words: tick adds elapsed time, load
// writes one duration entry, restart returns to first_frame going forward.
// rsp (source) returns one word per command: current frame, whether the
// frame moved, and the ping-pong direction flag.
// config: wr_en/wr_index/wr_data write first_frame, last_frame, play_mode;
// write only while no command is in flight.
// load, restart and unknown commands go from accept straight to ST_DONE,
// which loads the rsp output register. a tick passes ST_SUM, and also ST_DIV when
// the timer reaches a nonzero frame duration: the remainder comes from one shared
// subtractor doing a restoring division, one quotient bit per cycle.
// req.ready is low from accept until the result is moved into the rsp
// output register, so one command is worked on at a time.
// a finished word waits in the output register while rsp.ready is low; a
// new command can be accepted meanwhile, and its result waits in its last
// state until the register frees up.
// reset clears timer, frame and config, sets direction forward. the
// duration table is not cleared: every entry must be loaded before use.
`default_nettype none

module sprite_frame_sequencer #(
    parameter int FRAME_COUNT = 64,
    parameter int TIME_BITS   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    sfs_stream_if.sink                         req,
    sfs_stream_if.source                       rsp,
    input  wire logic                          wr_en,
    input  wire logic [sfs_pkg::REG_IDX_W-1:0]  wr_index,
    input  wire logic [sfs_pkg::REG_DATA_W-1:0] wr_data
);

    localparam int AW = $clog2(FRAME_COUNT);
    // one extra bit so the table depth itself fits in the index compare
    localparam int IW = ((AW > sfs_pkg::FRAME_W) ? AW : sfs_pkg::FRAME_W) + 1;
    localparam int SW = ((TIME_BITS > sfs_pkg::ELAPSED_W) ? TIME_BITS
                                                          : sfs_pkg::ELAPSED_W) + 1;
    localparam int CW = $clog2(TIME_BITS);
    localparam int FW = sfs_pkg::FRAME_W;

    sfs_pkg::state_t state_reg, state_next;

    logic [FW-1:0]             first_reg, last_reg;
    logic [sfs_pkg::MODE_W-1:0] mode_reg;
    logic [TIME_BITS-1:0]      time_reg, time_next;
    logic [FW-1:0]             frame_reg, frame_next;
    logic                      forward_reg, forward_next;
    logic [FW-1:0]             old_frame_reg, old_frame_next;
    logic [sfs_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]      div_q_reg, div_q_next;
    logic [TIME_BITS-1:0]      div_r_reg, div_r_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    sfs_pkg::sfs_out_t         rsp_data_reg, rsp_data_next;

    logic                      accept;
    logic                      done_load;
    logic [AW-1:0]             frame_addr_tab [sfs_pkg::FRAME_SPAN];
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [TIME_BITS-1:0]      ram_wdata;
    logic [TIME_BITS-1:0]      dur;
    logic                      index_ok;
    logic [SW-1:0]             dur_ext;
    logic [SW-1:0]             sum_wide;
    logic [TIME_BITS-1:0]      sum_sat;
    logic [TIME_BITS:0]        shifted;
    logic [TIME_BITS:0]        diff;
    logic [TIME_BITS-1:0]      rem_step;
    logic                      last_step;
    logic [FW:0]               f_up, f_dn;
    logic [FW:0]               lo, hi;
    logic                      at_zero;
    logic [FW-1:0]             adv_frame;
    logic                      adv_forward;

    // frame number to table address: frame modulo the table depth
    genvar gi;
    generate
        for (gi = 0; gi < sfs_pkg::FRAME_SPAN; gi++)
        begin : g_addr
            assign frame_addr_tab[gi] = AW'(gi % FRAME_COUNT);
        end
    endgenerate

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == sfs_pkg::ST_IDLE);
    assign done_load = (state_reg == sfs_pkg::ST_DONE) && (!rsp_valid_reg || rsp.ready);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    assign index_ok  = IW'(req.payload.entry_index) < IW'(FRAME_COUNT);
    assign dur_ext   = SW'(req.payload.entry_duration);
    assign ram_we    = accept && (req.payload.command == sfs_pkg::CMD_LOAD) && index_ok;
    assign ram_waddr = AW'(req.payload.entry_index);
    assign ram_wdata = dur_ext[TIME_BITS-1:0];

    sfs_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (FRAME_COUNT)
    ) u_dur_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (frame_addr_tab[frame_reg]),
        .rdata (dur)
    );

    // saturating accumulate
    assign sum_wide = SW'(time_reg) + SW'(elapsed_reg);
    assign sum_sat  = (sum_wide > SW'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
                                                          : sum_wide[TIME_BITS-1:0];

    // shared subtractor: one restoring division step per cycle
    assign shifted   = {div_r_reg, div_q_reg[TIME_BITS-1]};
    assign diff      = shifted - {1'b0, dur};
    assign rem_step  = diff[TIME_BITS] ? shifted[TIME_BITS-1:0] : diff[TIME_BITS-1:0];
    assign last_step = (cnt_reg == CW'(TIME_BITS - 1));

    // frame step, bounds compared one bit wider so 63+1 stays 64
    assign lo      = {1'b0, first_reg};
    assign hi      = {1'b0, last_reg};
    assign f_up    = {1'b0, frame_reg} + 1'b1;
    assign f_dn    = {1'b0, frame_reg} - 1'b1;
    assign at_zero = (frame_reg == '0);

    always_comb
    begin
        adv_frame   = frame_reg;
        adv_forward = forward_reg;
        case (mode_reg)
            sfs_pkg::MODE_FORWARD:
            begin
                if (f_up > hi || f_up < lo)
                    adv_frame = first_reg;
                else
                    adv_frame = f_up[FW-1:0];
            end
            sfs_pkg::MODE_BACKWARD:
            begin
                // zero minus one is below any lower bound
                if (at_zero || f_dn < lo || f_dn > hi)
                    adv_frame = last_reg;
                else
                    adv_frame = f_dn[FW-1:0];
            end
            sfs_pkg::MODE_PINGPONG:
            begin
                if (forward_reg)
                begin
                    if (f_up > hi)
                    begin
                        adv_frame   = last_reg;
                        adv_forward = 1'b0;
                    end
                    else if (f_up < lo)
                        adv_frame = first_reg;
                    else
                        adv_frame = f_up[FW-1:0];
                end
                else
                begin
                    if (at_zero || f_dn < lo)
                    begin
                        adv_frame   = first_reg;
                        adv_forward = 1'b1;
                    end
                    else if (f_dn > hi)
                        adv_frame = last_reg;
                    else
                        adv_frame = f_dn[FW-1:0];
                end
            end
            default:
            begin
                adv_frame   = frame_reg;
                adv_forward = forward_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.payload.command == sfs_pkg::CMD_TICK)
                        state_next = sfs_pkg::ST_SUM;
                    else
                        state_next = sfs_pkg::ST_DONE;
                end
            end
            sfs_pkg::ST_SUM:
            begin
                if (sum_sat >= dur && dur != '0)
                    state_next = sfs_pkg::ST_DIV;
                else
                    state_next = sfs_pkg::ST_DONE;
            end
            sfs_pkg::ST_DIV:
            begin
                if (last_step)
                    state_next = sfs_pkg::ST_DONE;
            end
            sfs_pkg::ST_DONE:
            begin
                if (done_load)
                    state_next = sfs_pkg::ST_IDLE;
            end
            default:
                state_next = sfs_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        time_next      = time_reg;
        frame_next     = frame_reg;
        forward_next   = forward_reg;
        old_frame_next = old_frame_reg;
        elapsed_next   = elapsed_reg;
        div_q_next     = div_q_reg;
        div_r_next     = div_r_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;

        if (rsp.ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            sfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    old_frame_next = frame_reg;
                    elapsed_next   = req.payload.elapsed;
                    if (req.payload.command == sfs_pkg::CMD_RESTART)
                    begin
                        time_next    = '0;
                        frame_next   = first_reg;
                        forward_next = 1'b1;
                    end
                end
            end
            sfs_pkg::ST_SUM:
            begin
                if (sum_sat >= dur)
                begin
                    if (dur == '0)
                    begin
                        time_next    = '0;
                        frame_next   = adv_frame;
                        forward_next = adv_forward;
                    end
                    else
                    begin
                        time_next  = sum_sat;
                        div_q_next = sum_sat;
                        div_r_next = '0;
                        cnt_next   = '0;
                    end
                end
                else
                    time_next = sum_sat;
            end
            sfs_pkg::ST_DIV:
            begin
                div_r_next = rem_step;
                div_q_next = {div_q_reg[TIME_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (last_step)
                begin
                    time_next    = rem_step;
                    frame_next   = adv_frame;
                    forward_next = adv_forward;
                end
            end
            sfs_pkg::ST_DONE:
            begin
                if (done_load)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.frame_now     = frame_reg;
                    rsp_data_next.frame_changed = (frame_reg != old_frame_reg);
                    rsp_data_next.going_forward = forward_reg;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfs_pkg::ST_IDLE;
            first_reg     <= '0;
            last_reg      <= '0;
            mode_reg      <= sfs_pkg::MODE_FORWARD;
            time_reg      <= '0;
            frame_reg     <= '0;
            forward_reg   <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            frame_reg     <= frame_next;
            forward_reg   <= forward_next;
            rsp_valid_reg <= rsp_valid_next;
            if (wr_en)
            begin
                case (wr_index)
                    sfs_pkg::REG_FIRST_FRAME: first_reg <= wr_data[FW-1:0];
                    sfs_pkg::REG_LAST_FRAME:  last_reg  <= wr_data[FW-1:0];
                    sfs_pkg::REG_PLAY_MODE:   mode_reg  <= wr_data[sfs_pkg::MODE_W-1:0];
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        old_frame_reg <= old_frame_next;
        elapsed_reg   <= elapsed_next;
        div_q_reg     <= div_q_next;
        div_r_reg     <= div_r_next;
        cnt_reg       <= cnt_next;
        rsp_data_reg  <= rsp_data_next;
    end

endmodule

`default_nettype wire

### rtl/core/sfs_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module sfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/sfs_checker.sv
// port-level checks for the sprite frame sequencer, bound to the top level
`default_nettype none

module sfs_port_props (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_ready,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire sfs_pkg::sfs_out_t    rsp_payload
);

    // a stalled result word stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("rsp word dropped or changed while stalled");

    // one command at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req accepted while previous command still busy");

    // a new result word lands as the block goes from busy back to idle
    a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> req_ready && $past(!req_ready))
        else $error("rsp word appeared without finishing a command");

endmodule

bind sprite_frame_sequencer sfs_port_props u_sfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

`default_nettype wire

### bench/sfs_checker.sv
`timescale 1ns / 100ps
// response checker: predicts every sequencer word and compares it with the block
module sfs_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    sfs_stream_if                          req_mon,
    sfs_stream_if                          rsp_mon,
    input  logic                           wr_en,
    input  logic [sfs_pkg::REG_IDX_W-1:0]  wr_index,
    input  logic [sfs_pkg::REG_DATA_W-1:0] wr_data,
    output int                             fail_count,
    output int                             pending
);

    logic [sfs_pkg::DUR_W-1:0]   dur_table [sfs_pkg::FRAME_SPAN];
    logic [sfs_pkg::DUR_W-1:0]   timer;
    logic [sfs_pkg::FRAME_W-1:0] frame;
    logic                        fwd;
    logic [sfs_pkg::FRAME_W-1:0] lo_frame;
    logic [sfs_pkg::FRAME_W-1:0] hi_frame;
    logic [sfs_pkg::MODE_W-1:0]  mode;
    sfs_pkg::sfs_out_t           frame_q [$];

    // bounds are applied on signed values so 0-1 and 63+1 leave the 6-bit range
    function automatic void step_frame();
        int lo;
        int hi;
        int f;
        lo = lo_frame;
        hi = hi_frame;
        f  = frame;
        case (mode)
            sfs_pkg::MODE_FORWARD:
            begin
                f = f + 1;
                if (f > hi || f < lo)
                    f = lo;
            end
            sfs_pkg::MODE_BACKWARD:
            begin
                f = f - 1;
                if (f < lo || f > hi)
                    f = hi;
            end
            sfs_pkg::MODE_PINGPONG:
            begin
                if (fwd)
                begin
                    f = f + 1;
                    if (f > hi)
                    begin
                        f   = hi;
                        fwd = 1'b0;
                    end
                    else if (f < lo)
                        f = lo;
                end
                else
                begin
                    f = f - 1;
                    if (f < lo)
                    begin
                        f   = lo;
                        fwd = 1'b1;
                    end
                    else if (f > hi)
                        f = hi;
                end
            end
            default: ;  // hold mode: frame and direction stay
        endcase
        frame = f[sfs_pkg::FRAME_W-1:0];
    endfunction

    function automatic sfs_pkg::sfs_out_t apply_word(input sfs_pkg::sfs_in_t w);
        sfs_pkg::sfs_out_t           r;
        logic [sfs_pkg::FRAME_W-1:0] was;
        logic [sfs_pkg::DUR_W:0]     sum;
        logic [sfs_pkg::DUR_W-1:0]   dur;
        was = frame;
        case (w.command)
            sfs_pkg::CMD_TICK:
            begin
                dur = dur_table[frame];
                sum = timer + w.elapsed;
                // saturate rather than wrap
                timer = (sum > {1'b0, {sfs_pkg::DUR_W{1'b1}}}) ? '1
                                                               : sum[sfs_pkg::DUR_W-1:0];
                if (timer >= dur)
                begin
                    timer = (dur == '0) ? '0 : timer % dur;
                    step_frame();
                end
            end
            sfs_pkg::CMD_LOAD:
                dur_table[w.entry_index] = w.entry_duration;
            sfs_pkg::CMD_RESTART:
            begin
                timer = '0;
                frame = lo_frame;
                fwd   = 1'b1;
            end
            default: ;
        endcase
        r.frame_now     = frame;
        r.frame_changed = (frame != was);
        r.going_forward = fwd;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sfs_pkg::sfs_out_t got;
        sfs_pkg::sfs_out_t want;
        int                errs;
        errs = 0;
        if (!rst_n)
        begin
            timer    = '0;
            frame    = '0;
            fwd      = 1'b1;
            lo_frame = '0;
            hi_frame = '0;
            mode     = sfs_pkg::MODE_FORWARD;
            frame_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    sfs_pkg::REG_FIRST_FRAME: lo_frame = wr_data[sfs_pkg::FRAME_W-1:0];
                    sfs_pkg::REG_LAST_FRAME:  hi_frame = wr_data[sfs_pkg::FRAME_W-1:0];
                    sfs_pkg::REG_PLAY_MODE:   mode     = wr_data[sfs_pkg::MODE_W-1:0];
                    default: ;
                endcase
            end
            // retire before predicting: a word leaving now belongs to an older command
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                got = rsp_mon.payload;
                if (frame_q.size() == 0)
                begin
                    $display("%0t: word with nothing expected: frame %0d changed %0d fwd %0d",
                             $time, got.frame_now, got.frame_changed, got.going_forward);
                    errs++;
                end
                else
                begin
                    want = frame_q.pop_front();
                    if (got.frame_now !== want.frame_now)
                    begin
                        $display("%0t: frame_now expected %0d, got %0d",
                                 $time, want.frame_now, got.frame_now);
                        errs++;
                    end
                    if (got.frame_changed !== want.frame_changed)
                    begin
                        $display("%0t: frame_changed expected %0d, got %0d",
                                 $time, want.frame_changed, got.frame_changed);
                        errs++;
                    end
                    if (got.going_forward !== want.going_forward)
                    begin
                        $display("%0t: going_forward expected %0d, got %0d",
                                 $time, want.going_forward, got.going_forward);
                        errs++;
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
                frame_q.push_back(apply_word(req_mon.payload));
            fail_count <= fail_count + errs;
            pending    <= frame_q.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// sequencer bench top: clock, reset, command stimulus, stalls and verdict
module tb;

    localparam logic [sfs_pkg::CMD_W-1:0]     CMD_NONE    = 2'd3;
    localparam logic [sfs_pkg::MODE_W-1:0]    MODE_HOLD   = 2'd3;
    localparam logic [sfs_pkg::REG_IDX_W-1:0] REG_SPARE   = 2'd3;
    localparam int                            QUIET_LIMIT = 2000;
    localparam int                            PHASES      = 13;
    localparam int                            PHASE_WORDS = 100;

    logic                           clk;
    logic                           rst_n;
    logic                           wr_en;
    logic [sfs_pkg::REG_IDX_W-1:0]  wr_index;
    logic [sfs_pkg::REG_DATA_W-1:0] wr_data;
    int                             fail_count;
    int                             pending;
    int                             gap_odds;    // chance in 16 of an idle burst, 0 for none
    int                             stall_odds;
    int                             words_sent;
    int                             ticks_sent;
    int                             settings_used;
    int                             quiet;

    sfs_stream_if #(.payload_t(sfs_pkg::sfs_in_t))  req_ch ();
    sfs_stream_if #(.payload_t(sfs_pkg::sfs_out_t)) rsp_ch ();

    sprite_frame_sequencer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    sfs_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_mon    (req_ch),
        .rsp_mon    (rsp_ch),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver side: random stall bursts
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_odds != 0 && $urandom_range(1, 16) <= stall_odds)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet <= 0;
        else if (quiet + 1 >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("** sprite_frame_sequencer: FAILED **");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic send_word(input logic [sfs_pkg::CMD_W-1:0] cmd,
                             input logic [sfs_pkg::ELAPSED_W-1:0] el,
                             input logic [sfs_pkg::FRAME_W-1:0] idx,
                             input logic [sfs_pkg::DUR_W-1:0] dur);
        sfs_pkg::sfs_in_t w;
        w.command        = cmd;
        w.elapsed        = el;
        w.entry_index    = idx;
        w.entry_duration = dur;
        if (gap_odds != 0 && $urandom_range(1, 16) <= gap_odds)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        words_sent++;
        if (cmd == sfs_pkg::CMD_TICK)
            ticks_sent++;
    endtask

    task automatic tick_full(input int n);
        repeat (n)
            send_word(sfs_pkg::CMD_TICK, '1, sfs_pkg::FRAME_W'($urandom),
                      sfs_pkg::DUR_W'($urandom));
    endtask

    // only called with nothing in flight
    task automatic set_anim(input logic [sfs_pkg::FRAME_W-1:0] first,
                            input logic [sfs_pkg::FRAME_W-1:0] last,
                            input logic [sfs_pkg::MODE_W-1:0] mode, input bit spare);
        wr_en    <= 1'b1;
        wr_index <= sfs_pkg::REG_FIRST_FRAME;
        wr_data  <= sfs_pkg::REG_DATA_W'(first);
        @(posedge clk);
        wr_index <= sfs_pkg::REG_LAST_FRAME;
        wr_data  <= sfs_pkg::REG_DATA_W'(last);
        @(posedge clk);
        wr_index <= sfs_pkg::REG_PLAY_MODE;
        wr_data  <= sfs_pkg::REG_DATA_W'(mode);
        @(posedge clk);
        if (spare)
        begin
            wr_index <= REG_SPARE;
            wr_data  <= sfs_pkg::REG_DATA_W'($urandom);
            @(posedge clk);
        end
        wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // covers a tick that runs the full division
        repeat (25) @(posedge clk);
    endtask

    function automatic logic [sfs_pkg::DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return sfs_pkg::DUR_W'($urandom);
            default: return sfs_pkg::DUR_W'($urandom_range(1, 400));
        endcase
    endfunction

    function automatic logic [sfs_pkg::ELAPSED_W-1:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return sfs_pkg::ELAPSED_W'($urandom);
            default: return sfs_pkg::ELAPSED_W'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic send_random();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 62)
            send_word(sfs_pkg::CMD_TICK, pick_elapsed(), sfs_pkg::FRAME_W'($urandom),
                      sfs_pkg::DUR_W'($urandom));
        else if (pick < 82)
            send_word(sfs_pkg::CMD_LOAD, sfs_pkg::ELAPSED_W'($urandom),
                      sfs_pkg::FRAME_W'($urandom), pick_duration());
        else if (pick < 94)
            send_word(sfs_pkg::CMD_RESTART, sfs_pkg::ELAPSED_W'($urandom),
                      sfs_pkg::FRAME_W'($urandom), sfs_pkg::DUR_W'($urandom));
        else
            send_word(CMD_NONE, sfs_pkg::ELAPSED_W'($urandom),
                      sfs_pkg::FRAME_W'($urandom), sfs_pkg::DUR_W'($urandom));
    endtask

    task automatic random_setting();
        logic [sfs_pkg::FRAME_W-1:0] a;
        logic [sfs_pkg::FRAME_W-1:0] b;
        logic [sfs_pkg::MODE_W-1:0]  m;
        case ($urandom_range(0, 3))
            0:
            begin
                // narrow window, so ping-pong turns often
                a = sfs_pkg::FRAME_W'($urandom);
                b = a + sfs_pkg::FRAME_W'($urandom_range(0, 4));
                if (b < a)
                    b = '1;
            end
            1:
            begin
                a = sfs_pkg::FRAME_W'($urandom);
                b = sfs_pkg::FRAME_W'($urandom);
            end
            2:
            begin
                a = $urandom_range(0, 1) ? '1 : '0;
                b = $urandom_range(0, 1) ? '1 : '0;
            end
            default:
            begin
                a = sfs_pkg::FRAME_W'($urandom);
                b = a;
            end
        endcase
        m = ($urandom_range(0, 11) == 0) ? MODE_HOLD
                                          : sfs_pkg::MODE_W'($urandom_range(0, 2));
        set_anim(a, b, m, $urandom_range(0, 4) == 0);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        wr_en          <= 1'b0;
        wr_index       <= '0;
        wr_data        <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        gap_odds   = 0;
        stall_odds = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the table is undefined after reset: fill it before the first tick
        for (int i = 0; i < sfs_pkg::FRAME_SPAN; i++)
            send_word(sfs_pkg::CMD_LOAD, sfs_pkg::ELAPSED_W'($urandom),
                      sfs_pkg::FRAME_W'(i), pick_duration());
        drain();

        set_anim('0, '1, sfs_pkg::MODE_FORWARD, 1'b0);
        send_word(sfs_pkg::CMD_LOAD, '1, '0, '0);
        send_word(sfs_pkg::CMD_LOAD, '0, 6'd1, 16'd5);
        send_word(sfs_pkg::CMD_LOAD, '0, 6'd2, '1);
        send_word(sfs_pkg::CMD_LOAD, '0, '1, '1);
        send_word(sfs_pkg::CMD_RESTART, '0, '0, '0);
        send_word(sfs_pkg::CMD_TICK, '0, '0, '0);           // zero duration steps at once
        send_word(sfs_pkg::CMD_TICK, '1, '0, '0);           // remainder of a full-scale tick
        send_word(sfs_pkg::CMD_TICK, 16'd40000, '0, '0);
        send_word(sfs_pkg::CMD_TICK, '1, '0, '0);           // timer saturates
        send_word(CMD_NONE, '1, '1, '1);
        drain();

        // wrap past the top frame
        set_anim(6'd62, '1, sfs_pkg::MODE_FORWARD, 1'b0);
        send_word(sfs_pkg::CMD_RESTART, '0, '0, '0);
        send_word(sfs_pkg::CMD_LOAD, '0, 6'd62, '0);
        tick_full(3);
        drain();

        // first frame above last frame
        set_anim(6'd40, 6'd10, sfs_pkg::MODE_BACKWARD, 1'b1);
        send_word(sfs_pkg::CMD_RESTART, '0, '0, '0);
        tick_full(2);
        drain();

        // step below frame zero
        set_anim('0, 6'd5, sfs_pkg::MODE_BACKWARD, 1'b0);
        send_word(sfs_pkg::CMD_RESTART, '0, '0, '0);
        tick_full(1);
        drain();

        set_anim(6'd61, '1, sfs_pkg::MODE_PINGPONG, 1'b0);
        send_word(sfs_pkg::CMD_RESTART, '0, '0, '0);
        tick_full(6);
        drain();

        set_anim(6'd5, 6'd9, MODE_HOLD, 1'b0);
        send_word(sfs_pkg::CMD_RESTART, '0, '0, '0);
        tick_full(2);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            random_setting();
            if (p == PHASES - 1 || p % 3 == 0)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else if (p % 3 == 1)
            begin
                gap_odds   = 3;
                stall_odds = 3;
            end
            else
            begin
                gap_odds   = 8;
                stall_odds = 6;
            end
            if ($urandom_range(0, 1))
                send_word(sfs_pkg::CMD_RESTART, '0, '0, '0);
            repeat (PHASE_WORDS) send_random();
            drain();
        end

        $display("%0d command words, %0d of them ticks, under %0d animation settings",
                 words_sent, ticks_sent, settings_used);
        $display("covered all play modes, zero and full-scale durations, timer saturation");
        if (fail_count == 0)
            $display("** sprite_frame_sequencer: PASSED **");
        else
            $display("** sprite_frame_sequencer: FAILED **");
        $finish;
    end

endmodule
